[hw/rtl/base58_block_encoder_macros.svh]
// Assertion macros shared by the base-58 block encoder RTL.
`ifndef BASE58_BLOCK_ENCODER_MACROS_SVH
`define BASE58_BLOCK_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// General property, checked on every rising clock edge outside reset.
`define B58_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Condition that must never be true outside reset.
`define B58_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define B58_ASSERT(label, prop, msg)
`define B58_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[hw/rtl/b58_pkg.sv]
// Package with widths, types and lookup functions of the base-58 block encoder.
package b58_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned BLOCK_BYTES = 8;
  localparam int unsigned BLOCK_W     = BLOCK_BYTES * BYTE_W;
  localparam int unsigned MAX_CHARS   = 11;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned DCNT_W      = 4;
  localparam int unsigned STACK_W     = MAX_CHARS * DIGIT_W;

  localparam logic [DIGIT_W:0]   RADIX_EXT      = (DIGIT_W + 1)'(58);
  localparam logic [DIGIT_W-1:0] RADIX_DIG      = DIGIT_W'(58);
  localparam logic [CNT_W-1:0]   LAST_BYTE_IDX  = CNT_W'(BLOCK_BYTES - 1);
  localparam logic [DCNT_W-1:0]  MAX_CHARS_CNT  = DCNT_W'(MAX_CHARS);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } b58_state_e;

  // Control from the sequencer to the digit stack.
  typedef struct packed {
    logic               push;
    logic [DIGIT_W-1:0] digit;
    logic               emit;
    logic               msg_last;
  } b58_stk_ctrl_t;

  // Status from the digit stack to the sequencer.
  typedef struct packed {
    logic drained;
  } b58_stk_sts_t;

  // Number of characters for a block of n bytes (1 to 8).
  function automatic logic [DCNT_W-1:0] b58_char_len(input logic [DCNT_W-1:0] n);
    logic [DCNT_W-1:0] len;
    case (n)
      4'd1:    len = 4'd2;
      4'd2:    len = 4'd3;
      4'd3:    len = 4'd5;
      4'd4:    len = 4'd6;
      4'd5:    len = 4'd7;
      4'd6:    len = 4'd9;
      4'd7:    len = 4'd10;
      default: len = MAX_CHARS_CNT;
    endcase
    return len;
  endfunction

  // ASCII character of one base-58 digit; the alphabet skips 0, O, I and l.
  function automatic logic [CHAR_W-1:0] b58_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    logic [CHAR_W-1:0] c;
    dx = {1'b0, d};
    if (d < 6'd9) begin
      c = 7'd49 + dx;
    end else if (d < 6'd17) begin
      c = 7'd65 + dx - 7'd9;
    end else if (d < 6'd22) begin
      c = 7'd74 + dx - 7'd17;
    end else if (d < 6'd33) begin
      c = 7'd80 + dx - 7'd22;
    end else if (d < 6'd44) begin
      c = 7'd97 + dx - 7'd33;
    end else if (d < RADIX_DIG) begin
      c = 7'd109 + dx - 7'd44;
    end else begin
      c = 7'd49;
    end
    return c;
  endfunction

endpackage

[hw/rtl/b58_ifs.sv]
// Valid/ready channel interfaces for input bytes and output characters.
interface b58_in_if
  import b58_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b58_out_if
  import b58_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              block_end;
  logic              message_end;

  modport source (output valid, output out_char, output block_end, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input block_end, input message_end,
                  output ready);
endinterface

[hw/rtl/b58_divstep.sv]
// Shared divide-by-58 step: one byte of a long division per cycle.
module b58_divstep
  import b58_pkg::*;
(
  input  logic [DIGIT_W-1:0] rem_i,
  input  logic [BYTE_W-1:0]  byte_i,
  output logic [BYTE_W-1:0]  quot_o,
  output logic [DIGIT_W-1:0] rem_o
);

  // Restoring division of {rem, byte} by 58, one quotient bit per step.
  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] r;
    r      = rem_i;
    quot_o = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      trial = {r, byte_i[i]};
      if (trial >= RADIX_EXT) begin
        quot_o[i] = 1'b1;
        r         = DIGIT_W'(trial - RADIX_EXT);
      end else begin
        r = DIGIT_W'(trial);
      end
    end
    rem_o = r;
  end

endmodule

[hw/rtl/b58_digit_stack.sv]
// Digit stack that reverses the digit order and drives the output register.
`include "base58_block_encoder_macros.svh"
module b58_digit_stack
  import b58_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b58_stk_ctrl_t ctrl_i,
  output b58_stk_sts_t  sts_o,
  b58_out_if.source     out_o
);

  logic [STACK_W-1:0] digits_q;
  logic [DCNT_W-1:0]  depth_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               blk_end_q;
  logic               msg_end_q;
  logic               load;

  // During emission, pop the top digit whenever the output register is free or being taken.
  assign load = ctrl_i.emit && (depth_q != '0) && (!out_valid_q || out_o.ready);

  // Stack depth and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.push) begin
        depth_q <= depth_q + 1'b1;
      end else if (load) begin
        depth_q <= depth_q - 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Digit storage and output payload; the last digit pushed leaves first.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      digits_q <= {digits_q[STACK_W-DIGIT_W-1:0], ctrl_i.digit};
    end else if (load) begin
      digits_q <= {DIGIT_W'(0), digits_q[STACK_W-1:DIGIT_W]};
    end
    if (load) begin
      out_char_q <= b58_ascii(digits_q[DIGIT_W-1:0]);
      blk_end_q  <= (depth_q == DCNT_W'(1));
      msg_end_q  <= (depth_q == DCNT_W'(1)) && ctrl_i.msg_last;
    end
  end

  assign sts_o.drained     = (depth_q == '0) && !out_valid_q;
  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = out_char_q;
  assign out_o.block_end   = blk_end_q;
  assign out_o.message_end = msg_end_q;

  `B58_ASSERT(a_push_room, ctrl_i.push |-> (depth_q < MAX_CHARS_CNT), "digit stack overflow")
  `B58_ASSERT_NEVER(a_push_emit, ctrl_i.push && ctrl_i.emit, "push during emission")
  `B58_ASSERT(a_blk_end_empty, (out_valid_q && blk_end_q) |-> (depth_q == '0), "block end with digits left")

endmodule

[hw/rtl/base58_block_encoder.sv]
// Base-58 block encoder: bytes are gathered big-endian into blocks of eight, and
// each full block, or the final partial block of 1 to 7 bytes, leaves as a fixed
// run of 11, or 2, 3, 5, 6, 7, 9 or 10, base-58 characters, most significant
// first and padded with '1'. A byte that does not close a block leaves the
// encoder idle and ready for the next byte. A byte that closes a block starts the
// conversion: a shared byte-serial divide-by-58 unit walks the 64-bit block value
// once per digit and pushes each remainder onto a digit stack. Output then loads
// the first character, delivers one character per cycle while the sink is ready,
// and falls back to idle once the last character has been delivered. The input is
// therefore not ready while a block is divided and its characters are delivered.
// No input is taken until the last character of the run has been delivered.
`include "base58_block_encoder_macros.svh"
module base58_block_encoder
  import b58_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  b58_in_if.sink     in_i,
  b58_out_if.source  out_o
);

  b58_state_e          state_q, state_d;
  logic [BLOCK_W-1:0]  blk_q, blk_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    byte_idx_q, byte_idx_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [DCNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic [DCNT_W-1:0]   dig_total_q, dig_total_d;
  logic                msg_last_q, msg_last_d;
  logic                accept;
  logic                close_blk;
  logic [DCNT_W-1:0]   n_bytes;
  logic [BYTE_W-1:0]   quot;
  logic [DIGIT_W-1:0]  rem_new;
  b58_stk_ctrl_t       stk_ctrl;
  b58_stk_sts_t        stk_sts;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign n_bytes    = {1'b0, cnt_q} + DCNT_W'(1);
  assign close_blk  = (cnt_q == LAST_BYTE_IDX) || in_i.in_last;

  // Shared divide step works on the top byte of the block value.
  b58_divstep u_divstep (
    .rem_i  (rem_q),
    .byte_i (blk_q[BLOCK_W-1 -: BYTE_W]),
    .quot_o (quot),
    .rem_o  (rem_new)
  );

  // Sequencer: gather bytes, divide once per digit, then drain the digit stack.
  always_comb begin
    state_d     = state_q;
    blk_d       = blk_q;
    cnt_d       = cnt_q;
    byte_idx_d  = byte_idx_q;
    rem_d       = rem_q;
    dig_cnt_d   = dig_cnt_q;
    dig_total_d = dig_total_q;
    msg_last_d  = msg_last_q;
    stk_ctrl    = '0;
    stk_ctrl.digit    = rem_new;
    stk_ctrl.msg_last = msg_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          blk_d = {blk_q[BLOCK_W-BYTE_W-1:0], in_i.in_byte};
          if (close_blk) begin
            cnt_d       = '0;
            dig_total_d = b58_char_len(n_bytes);
            msg_last_d  = in_i.in_last;
            byte_idx_d  = '0;
            rem_d       = '0;
            dig_cnt_d   = '0;
            state_d     = ST_DIV;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_DIV: begin
        blk_d      = {blk_q[BLOCK_W-BYTE_W-1:0], quot};
        rem_d      = rem_new;
        byte_idx_d = byte_idx_q + 1'b1;
        if (byte_idx_q == LAST_BYTE_IDX) begin
          stk_ctrl.push = 1'b1;
          rem_d         = '0;
          dig_cnt_d     = dig_cnt_q + 1'b1;
          if (dig_cnt_q + 1'b1 == dig_total_q) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        stk_ctrl.emit = 1'b1;
        if (stk_sts.drained) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      blk_q      <= '0;
      cnt_q      <= '0;
      byte_idx_q <= '0;
      rem_q      <= '0;
      dig_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      blk_q      <= blk_d;
      cnt_q      <= cnt_d;
      byte_idx_q <= byte_idx_d;
      rem_q      <= rem_d;
      dig_cnt_q  <= dig_cnt_d;
    end
  end

  // Run length and message flag of the block being converted.
  always_ff @(posedge clk_i) begin
    dig_total_q <= dig_total_d;
    msg_last_q  <= msg_last_d;
  end

  b58_digit_stack u_digit_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (stk_ctrl),
    .sts_o  (stk_sts),
    .out_o  (out_o)
  );

  `B58_ASSERT(a_idle_drained, (state_q == ST_IDLE) |-> stk_sts.drained, "idle with output pending")
  `B58_ASSERT(a_rem_range, (state_q == ST_DIV) |-> (rem_q < RADIX_DIG), "remainder out of range")
  `B58_ASSERT(a_div_count, (state_q == ST_DIV) |-> (dig_cnt_q < dig_total_q), "too many digits")
  `B58_ASSERT(a_close_start, (accept && close_blk) |=> ((state_q == ST_DIV) && (byte_idx_q == '0) && (rem_q == '0)), "division start")

endmodule

[dv/b58_enc_checker.sv]
// Checker for the base-58 block encoder: predicts each character run and compares it.
module b58_enc_checker
  import b58_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CHAR_W-1:0] out_char_i,
  input  logic              block_end_i,
  input  logic              message_end_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       chars_checked_o,
  output int unsigned       runs_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RADIX = 58;
  localparam int unsigned REPORT_LIMIT = 10;
  // Digit symbols, digit 0 in the leftmost byte.
  localparam logic [8*58-1:0] SYMBOLS =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              blk_end;
    logic              msg_end;
  } b58_char_t;

  // Characters still owed by the encoder, oldest first.
  b58_char_t owed_chars_q[$];

  // Private copy of the block being gathered.
  logic [BLOCK_W-1:0] gathered_value;
  logic [2:0]         gathered_bytes;

  assign pending_o = owed_chars_q.size();

  // Append the character run of one block of nbytes bytes to the owed queue.
  function automatic void queue_block_chars(input logic [BLOCK_W-1:0] value,
                                            input int unsigned nbytes,
                                            input logic msg_final);
    int unsigned       width;
    logic [BLOCK_W-1:0] rest;
    logic [DIGIT_W-1:0] digits [MAX_CHARS];
    b58_char_t         c;
    case (nbytes)
      1:       width = 2;
      2:       width = 3;
      3:       width = 5;
      4:       width = 6;
      5:       width = 7;
      6:       width = 9;
      7:       width = 10;
      default: width = MAX_CHARS;
    endcase
    rest = value;
    // Least significant digit lands at the end of the run.
    for (int i = int'(width) - 1; i >= 0; i--) begin
      digits[i] = DIGIT_W'(rest % 64'(RADIX));
      rest      = rest / 64'(RADIX);
    end
    for (int i = 0; i < int'(width); i++) begin
      c.ch      = CHAR_W'(SYMBOLS[8*(57 - int'(digits[i])) +: 8]);
      c.blk_end = (i == int'(width) - 1);
      c.msg_end = c.blk_end && msg_final;
      owed_chars_q.push_back(c);
    end
  endfunction

  // Compare every output transaction, then fold every input transaction into the model.
  always @(posedge clk_i or negedge rst_ni) begin
    b58_char_t   want;
    int unsigned n;
    if (!rst_ni) begin
      owed_chars_q.delete();
      gathered_value  = '0;
      gathered_bytes  = '0;
      fail_count_o    = 0;
      chars_checked_o = 0;
      runs_checked_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_chars_q.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT) begin
            $display("%t checker: unexpected character 0x%02h block_end=%0b message_end=%0b",
                     $realtime, out_char_i, block_end_i, message_end_i);
          end
          fail_count_o++;
        end else begin
          want = owed_chars_q.pop_front();
          if (out_char_i !== want.ch || block_end_i !== want.blk_end ||
              message_end_i !== want.msg_end) begin
            if (fail_count_o < REPORT_LIMIT) begin
              $display("%t checker: mismatch, expected char 0x%02h be=%0b me=%0b, got 0x%02h be=%0b me=%0b",
                       $realtime, want.ch, want.blk_end, want.msg_end,
                       out_char_i, block_end_i, message_end_i);
            end
            fail_count_o++;
          end
          chars_checked_o++;
          if (want.blk_end) begin
            runs_checked_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        gathered_value = {gathered_value[BLOCK_W-BYTE_W-1:0], in_byte_i};
        n = int'(gathered_bytes) + 1;
        // A full block or the final byte of a message releases a run.
        if (n == BLOCK_BYTES || in_last_i) begin
          queue_block_chars(gathered_value, n, in_last_i);
          gathered_value = '0;
          gathered_bytes = '0;
        end else begin
          gathered_bytes = 3'(n);
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
// Top of the base-58 block encoder testbench: clock, reset, byte stimulus and verdict.
module testbench;
  import b58_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 150;
  localparam int unsigned DRAIN_CYCLES = 120;

  logic clk_i;
  logic rst_ni;
  logic steady;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned chars_checked;
  int unsigned runs_checked;

  b58_in_if  in_if ();
  b58_out_if out_if ();

  base58_block_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  b58_enc_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .in_ready_i      (in_if.ready),
    .in_byte_i       (in_if.in_byte),
    .in_last_i       (in_if.in_last),
    .out_valid_i     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_char_i      (out_if.out_char),
    .block_end_i     (out_if.block_end),
    .message_end_i   (out_if.message_end),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .chars_checked_o (chars_checked),
    .runs_checked_o  (runs_checked)
  );

  // Free-running clock, 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Character sink stalls about a third of the time outside the steady stretch.
  initial out_if.ready = 1'b0;
  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // Offer one byte, with random idle cycles ahead of it outside the steady stretch, and wait for its transaction.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (!steady) begin
      while ($urandom_range(0, 99) < 33) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
  endtask

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned rand_bytes;
    int unsigned msg_count;
    int unsigned len;
    int unsigned fill;
    logic [BYTE_W-1:0] b;
    rand_bytes     = 0;
    msg_count      = 0;
    steady         = 1'b0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = '0;
    in_if.in_last  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Shortest messages at both value extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Final byte closes a full block of the largest value.
    for (int k = 0; k < 8; k++) begin
      send_byte(8'hFF, k == 7);
    end
    // Zero full block that is not final, then a one-byte tail.
    for (int k = 0; k < 8; k++) begin
      send_byte(8'h00, 1'b0);
    end
    send_byte(8'h80, 1'b1);
    // Longest partial block at its largest value.
    for (int k = 0; k < 7; k++) begin
      send_byte(8'hFF, k == 6);
    end
    msg_count = 5;

    // Random messages, mostly up to one block, some spanning several.
    while (rand_bytes < RANDOM_BYTES) begin
      len  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      fill = $urandom_range(0, 9);
      for (int k = 0; k < int'(len); k++) begin
        steady = (rand_bytes >= 60 && rand_bytes < 110);
        if (fill == 0) begin
          b = 8'h00;
        end else if (fill == 1) begin
          b = 8'hFF;
        end else begin
          b = BYTE_W'($urandom_range(0, 255));
        end
        send_byte(b, k == int'(len) - 1);
        rand_bytes++;
      end
      msg_count++;
    end
    steady      = 1'b0;
    in_if.valid <= 1'b0;

    // Drain what is still owed, then watch for stray characters.
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d messages, %0d random bytes plus directed extremes",
             msg_count, rand_bytes);
    $display("summary: %0d characters in %0d runs compared, %0d mismatches",
             chars_checked, runs_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/b58_pkg.sv
hw/rtl/b58_ifs.sv
hw/rtl/b58_divstep.sv
hw/rtl/b58_digit_stack.sv
hw/rtl/base58_block_encoder.sv
dv/b58_enc_checker.sv
dv/testbench.sv
